// ===== design/tap_and_hold_gesture_classifier_core_assert.svh =====
// ---------------------------------------------------------------------------
// Tap-and-hold classifier assertion macros
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef TAP_AND_HOLD_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define TAP_AND_HOLD_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// Implication check: antecedent in one cycle, consequent in the same cycle.
`define TAHG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication check: consequent in the cycle after the antecedent.
`define TAHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tahg_pkg.sv =====
// ---------------------------------------------------------------------------
// tahg_pkg
// Shared widths, reset values, register indexes and types of the classifier.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tahg_pkg;

  // Internal timestamp width; differences wrap modulo 2^TIME_WIDTH
  localparam int TIME_WIDTH = 32;
  localparam int STAMP_W    = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int COUNT_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic [CFG_W-1:0] TAP_GAP_RESET = CFG_W'(400);
  localparam logic [CFG_W-1:0] HOLD_RESET    = CFG_W'(1500);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP_GAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_COUNTING = 2'd1,
    PH_HOLDING  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] tap_gap;
    logic [CFG_W-1:0] hold;
  } cfg_t;

  typedef struct packed {
    logic                  level;
    logic [TIME_WIDTH-1:0] stamp;
  } sample_t;

  typedef struct packed {
    logic               hold_event;
    logic               sequence_done;
    logic               single_tap_event;
    logic [COUNT_W-1:0] finished_taps;
    phase_t             current_phase;
  } result_t;

endpackage

`default_nettype wire

// ===== design/tahg_if.sv =====
// ---------------------------------------------------------------------------
// tahg_if
// Valid/ready channels of the classifier: samples, results, register writes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface tahg_smp_if;
  logic                         valid;
  logic                         ready;
  logic                         touch_level;
  logic [tahg_pkg::STAMP_W-1:0] time_ms;

  modport source (output valid, output touch_level, output time_ms, input ready);
  modport sink   (input valid, input touch_level, input time_ms, output ready);
endinterface

// Result channel
interface tahg_res_if;
  logic                         valid;
  logic                         ready;
  logic                         hold_event;
  logic                         sequence_done;
  logic                         single_tap_event;
  logic [tahg_pkg::COUNT_W-1:0] finished_taps;
  logic [1:0]                   current_phase;

  modport source (output valid, output hold_event, output sequence_done,
                  output single_tap_event, output finished_taps,
                  output current_phase, input ready);
  modport sink   (input valid, input hold_event, input sequence_done,
                  input single_tap_event, input finished_taps,
                  input current_phase, output ready);
endinterface

// Register write channel
interface tahg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tahg_pkg::CFG_IDX_W-1:0] index;
  logic [tahg_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tap_and_hold_gesture_classifier_core.sv =====
// ---------------------------------------------------------------------------
// tap_and_hold_gesture_classifier_core: multi-tap and long-press classifier
// Path: a taken sample is held in the input reg, then its result in the
//   result reg; a result waits there while the result sink stalls.
// Throughput: 1 sample per cycle unless stalled; gesture state updates once per sample.
// Reset: rst clears state to idle and loads tap gap 400 and hold 1500.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tap_and_hold_gesture_classifier_core (
  input  logic      clk,
  input  logic      rst,
  tahg_smp_if.sink  smp,
  tahg_res_if.source res,
  tahg_cfg_if.sink  cfg
);
  import tahg_pkg::*;

  cfg_t    regs;
  logic    vld;
  sample_t smpl;
  logic    take;

  // Registers
  tahg_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sample input stage
  tahg_in_reg u_in (
    .clk  (clk),
    .rst  (rst),
    .smp  (smp),
    .vld  (vld),
    .smpl (smpl),
    .take (take)
  );

  // Classification and result stage
  tahg_engine u_eng (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .vld  (vld),
    .smpl (smpl),
    .take (take),
    .res  (res)
  );

endmodule

`default_nettype wire

// ===== design/tahg_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// tahg_cfg_regs
// Tap gap and hold time registers; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tahg_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  tahg_cfg_if.sink       cfg,
  output tahg_pkg::cfg_t regs
);
  import tahg_pkg::*;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tap_gap <= TAP_GAP_RESET;
      regs.hold    <= HOLD_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_TAP_GAP) begin
        regs.tap_gap <= cfg.data;
      end
      if (cfg.index == REG_HOLD) begin
        regs.hold <= cfg.data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tahg_in_reg.sv =====
// ---------------------------------------------------------------------------
// tahg_in_reg
// Input register stage for touch samples.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tahg_in_reg (
  input  logic              clk,
  input  logic              rst,
  tahg_smp_if.sink          smp,
  output logic              vld,
  output tahg_pkg::sample_t smpl,
  input  logic              take
);
  import tahg_pkg::*;

  // Free slot, or the held item moves on this cycle
  assign smp.ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (smp.ready) begin
      vld <= smp.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (smp.valid && smp.ready) begin
      smpl.level <= smp.touch_level;
      smpl.stamp <= TIME_WIDTH'(smp.time_ms);
    end
  end

endmodule

`default_nettype wire

// ===== design/tahg_engine.sv =====
// ---------------------------------------------------------------------------
// tahg_engine
// Gesture state, single-pass classification of one sample and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tahg_engine (
  input  logic              clk,
  input  logic              rst,
  input  tahg_pkg::cfg_t    regs,
  input  logic              vld,
  input  tahg_pkg::sample_t smpl,
  output logic              take,
  tahg_res_if.source        res
);
  import tahg_pkg::*;

  // Gesture state
  phase_t                phase;
  phase_t                phase_next;
  logic                  prev_level;
  logic [COUNT_W-1:0]    tap_count;
  logic [COUNT_W-1:0]    tap_count_next;
  logic [TIME_WIDTH-1:0] press_start;
  logic [TIME_WIDTH-1:0] last_tap;

  // Result register
  logic    ovld;
  result_t res_q;
  result_t res_next;

  // Per-sample conditions
  logic                  rise;
  logic                  fall;
  logic                  extend;
  logic                  hold_hit;
  logic                  release_hit;
  logic                  timeout;
  logic [TIME_WIDTH-1:0] el_last;
  logic [TIME_WIDTH-1:0] el_start;
  logic [TIME_WIDTH-1:0] gap_w;
  logic [TIME_WIDTH-1:0] hold_w;

  // Output register frees up or is empty
  assign take = vld && (!ovld || res.ready);

  // Wrapping elapsed times and edge detection
  always_comb begin
    el_last  = smpl.stamp - last_tap;
    el_start = smpl.stamp - press_start;
    gap_w    = TIME_WIDTH'(regs.tap_gap);
    hold_w   = TIME_WIDTH'(regs.hold);
    rise     = !prev_level && smpl.level;
    fall     = prev_level && !smpl.level;
    // A tap strictly inside the gap extends the running sequence
    extend   = rise && (phase == PH_COUNTING) && (el_last < gap_w);
    // On a rising edge the press has just started, so no hold
    hold_hit = !rise && smpl.level && (phase == PH_COUNTING) &&
               (tap_count == COUNT_ONE) && (el_start > hold_w);
    release_hit = fall && (phase == PH_HOLDING);
    // Level low means no rising edge and no hold this sample
    timeout  = !smpl.level && (phase == PH_COUNTING) && (el_last > gap_w);
  end

  // Next state
  always_comb begin
    phase_next     = phase;
    tap_count_next = tap_count;
    priority if (rise) begin
      phase_next = PH_COUNTING;
      if (!extend) begin
        tap_count_next = COUNT_ONE;
      end else if (tap_count != COUNT_MAX) begin
        tap_count_next = tap_count + COUNT_ONE;
      end
    end else if (hold_hit) begin
      phase_next     = PH_HOLDING;
      tap_count_next = '0;
    end else if (release_hit) begin
      phase_next = PH_IDLE;
    end else if (timeout) begin
      phase_next     = PH_IDLE;
      tap_count_next = '0;
    end else begin
      phase_next = phase;
    end
  end

  // Result fields
  always_comb begin
    res_next.hold_event       = hold_hit;
    res_next.sequence_done    = timeout;
    res_next.single_tap_event = timeout && (tap_count == COUNT_ONE);
    res_next.finished_taps    = timeout ? tap_count : '0;
    res_next.current_phase    = phase_next;
  end

  // State update, one sample per take
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      prev_level  <= 1'b0;
      tap_count   <= '0;
      press_start <= '0;
      last_tap    <= '0;
    end else if (take) begin
      phase      <= phase_next;
      prev_level <= smpl.level;
      tap_count  <= tap_count_next;
      if (rise) begin
        press_start <= smpl.stamp;
        last_tap    <= smpl.stamp;
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (!ovld || res.ready) begin
      ovld <= vld;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign res.valid            = ovld;
  assign res.hold_event       = res_q.hold_event;
  assign res.sequence_done    = res_q.sequence_done;
  assign res.single_tap_event = res_q.single_tap_event;
  assign res.finished_taps    = res_q.finished_taps;
  assign res.current_phase    = res_q.current_phase;

endmodule

`default_nettype wire

// ===== design/tahg_checker.sv =====
// ---------------------------------------------------------------------------
// tahg_checker
// Port-level checks on the classifier results, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tap_and_hold_gesture_classifier_core_assert.svh"

module tahg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         hold_event,
  input logic                         sequence_done,
  input logic                         single_tap_event,
  input logic [tahg_pkg::COUNT_W-1:0] finished_taps,
  input logic [1:0]                   current_phase
);
  import tahg_pkg::*;

  // No finished count or single-tap flag outside a finished sequence
  `TAHG_ASSERT_SAME(a_idle_fields, res_valid && !sequence_done, (finished_taps == '0) && !single_tap_event, "result fields set without sequence_done")

  // A finished sequence always returns to idle, is never a hold and has taps
  `TAHG_ASSERT_SAME(a_done_idle, res_valid && sequence_done, (current_phase == PH_IDLE) && !hold_event && (finished_taps != '0), "finished sequence not idle")

  // A long press lands in the holding phase
  `TAHG_ASSERT_SAME(a_hold_phase, res_valid && hold_event, current_phase == PH_HOLDING, "hold event outside holding phase")

  // Stalled result holds
  `TAHG_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable({hold_event, sequence_done, single_tap_event, finished_taps, current_phase}), "stalled result changed")

endmodule

bind tap_and_hold_gesture_classifier_core tahg_checker u_chk (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .hold_event       (res.hold_event),
  .sequence_done    (res.sequence_done),
  .single_tap_event (res.single_tap_event),
  .finished_taps    (res.finished_taps),
  .current_phase    (res.current_phase)
);

`default_nettype wire

// ===== tb/tap_and_hold_gesture_classifier_core_tb.sv =====
// ---------------------------------------------------------------------------
// Tap-and-hold gesture classifier testbench
// Streams touch samples into the core and checks every result against a
// cycle-free model of the gesture state kept in a scoreboard. A short
// directed run hits the gap and hold boundaries, timestamp wrap and an
// ignored register index; a saturating tap burst and randomized gesture
// sequences follow under several register settings and stall profiles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_and_hold_gesture_classifier_core_tb;
  import tahg_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int TAIL_CYCLES     = 8;
  localparam int BURST_TAPS      = 258;

  // Index outside the register list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = {CFG_IDX_W{1'b1}};

  // Gesture state model and queue of expected results
  class gesture_scoreboard;
    logic [CFG_W-1:0]      tap_gap;
    logic [CFG_W-1:0]      hold;
    phase_t                phase;
    logic                  prev_level;
    logic [COUNT_W-1:0]    taps;
    logic [TIME_WIDTH-1:0] press_start;
    logic [TIME_WIDTH-1:0] last_tap;
    result_t               expected_q[$];
    int                    errors;

    function new();
      tap_gap     = TAP_GAP_RESET;
      hold        = HOLD_RESET;
      phase       = PH_IDLE;
      prev_level  = 1'b0;
      taps        = '0;
      press_start = '0;
      last_tap    = '0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(input string msg);
      if (errors < 50) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      errors++;
    endtask

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      if (idx == REG_TAP_GAP) begin
        tap_gap = val;
      end else if (idx == REG_HOLD) begin
        hold = val;
      end
    endfunction

    // Edge, hold, release, then timeout, all on the same sample
    function void note_sample(input logic level, input logic [TIME_WIDTH-1:0] now);
      result_t r;
      r = '0;
      if (!prev_level && level) begin
        press_start = now;
        if (phase == PH_COUNTING && TIME_WIDTH'(now - last_tap) < TIME_WIDTH'(tap_gap)) begin
          if (taps != COUNT_MAX) taps = taps + 1'b1;
        end else begin
          taps  = COUNT_ONE;
          phase = PH_COUNTING;
        end
        last_tap = now;
      end
      if (level && phase == PH_COUNTING && taps == COUNT_ONE &&
          TIME_WIDTH'(now - press_start) > TIME_WIDTH'(hold)) begin
        r.hold_event = 1'b1;
        phase        = PH_HOLDING;
        taps         = '0;
      end
      if (prev_level && !level && phase == PH_HOLDING) phase = PH_IDLE;
      if (phase == PH_COUNTING && !level &&
          TIME_WIDTH'(now - last_tap) > TIME_WIDTH'(tap_gap)) begin
        r.sequence_done    = 1'b1;
        r.finished_taps    = taps;
        r.single_tap_event = (taps == COUNT_ONE);
        taps               = '0;
        phase              = PH_IDLE;
      end
      prev_level      = level;
      r.current_phase = phase;
      expected_q.push_back(r);
    endfunction

    task check_result(input logic hold_ev, input logic done, input logic single,
                      input logic [COUNT_W-1:0] fin, input logic [1:0] ph);
      result_t e;
      if (expected_q.size() == 0) begin
        report("result with no sample outstanding");
        return;
      end
      e = expected_q.pop_front();
      if (hold_ev !== e.hold_event)
        report($sformatf("hold_event exp %0d got %0d", e.hold_event, hold_ev));
      if (done !== e.sequence_done)
        report($sformatf("sequence_done exp %0d got %0d", e.sequence_done, done));
      if (single !== e.single_tap_event)
        report($sformatf("single_tap_event exp %0d got %0d", e.single_tap_event, single));
      if (fin !== e.finished_taps)
        report($sformatf("finished_taps exp %0d got %0d", e.finished_taps, fin));
      if (ph !== e.current_phase)
        report($sformatf("current_phase exp %0d got %0d", e.current_phase, ph));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tahg_smp_if smp_bus ();
  tahg_res_if res_bus ();
  tahg_cfg_if cfg_bus ();

  tap_and_hold_gesture_classifier_core u_dut (
    .clk (clk),
    .rst (rst),
    .smp (smp_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  gesture_scoreboard sb = new();

  int          src_idle_pct  = 27;
  int          sink_idle_pct = 50;
  int          items_sent    = 0;
  int          quiet_cycles  = 0;
  logic [3:0]  hold_off_seq  = '0;
  logic [31:0] now_ms        = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Monitor: results first, then new samples and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (res_bus.valid && res_bus.ready)
        sb.check_result(res_bus.hold_event, res_bus.sequence_done, res_bus.single_tap_event,
                        res_bus.finished_taps, res_bus.current_phase);
      if (smp_bus.valid && smp_bus.ready)
        sb.note_sample(smp_bus.touch_level, TIME_WIDTH'(smp_bus.time_ms));
      if (cfg_bus.valid && cfg_bus.ready)
        sb.write_reg(cfg_bus.index, cfg_bus.data);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin
    logic [3:0] seen;
    seen = '0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_seq != seen) begin
        seen = hold_off_seq;
        res_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // One sample item; valid stays high for a following item
  task automatic send_sample(input logic level, input logic [31:0] stamp);
    if ($urandom_range(99) < src_idle_pct) begin
      smp_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    smp_bus.valid       <= 1'b1;
    smp_bus.touch_level <= level;
    smp_bus.time_ms     <= stamp;
    @(posedge clk);
    while (!smp_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    smp_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] hold_val,
                              input bit poke_unused);
    drain();
    put_reg(REG_TAP_GAP, gap);
    put_reg(REG_HOLD, hold_val);
    if (poke_unused) put_reg(REG_UNUSED, CFG_W'($urandom_range(0, 16'hFFFF)));
    cfg_bus.valid <= 1'b0;
  endtask

  // Time step around a threshold: under, on, over, or elsewhere
  function automatic logic [31:0] near(input logic [CFG_W-1:0] lim);
    logic [31:0] base;
    base = {16'h0, lim};
    case ($urandom_range(0, 5))
      0: near = base - 1;
      1: near = base;
      2: near = base + 1;
      3: near = $urandom_range(0, base);
      4: near = base + $urandom_range(2, 3000);
      default: near = $urandom_range(0, 20);
    endcase
  endfunction

  // One random gesture: taps, a long press, taps then a press, or noise
  task automatic play_gesture();
    int          kind;
    int          taps_n;
    logic [31:0] press_t;
    logic [31:0] held_t;
    kind    = $urandom_range(0, 9);
    press_t = now_ms + $urandom_range(1, 50);
    if (kind <= 4) begin
      taps_n = $urandom_range(1, 6);
      for (int k = 0; k < taps_n; k++) begin
        if (k != 0) press_t = press_t + near(sb.tap_gap);
        send_sample(1'b1, press_t);
        held_t = press_t;
        repeat ($urandom_range(0, 2)) begin
          held_t = held_t + $urandom_range(0, 40);
          send_sample(1'b1, held_t);
        end
        send_sample(1'b0, held_t + $urandom_range(0, 5));
      end
      // close the sequence: once around the gap, then past it
      send_sample(1'b0, press_t + near(sb.tap_gap));
      now_ms = press_t + sb.tap_gap + $urandom_range(1, 100);
      send_sample(1'b0, now_ms);
    end else if (kind <= 6) begin
      send_sample(1'b1, press_t);
      send_sample(1'b1, press_t + near(sb.hold));
      send_sample(1'b1, press_t + sb.hold + $urandom_range(0, 2));
      now_ms = press_t + sb.hold + $urandom_range(3, 500);
      send_sample(1'($urandom_range(0, 1)), now_ms);
      send_sample(1'b0, now_ms + 1);
    end else if (kind == 7) begin
      // second tap held long: no hold event during a multi-tap
      send_sample(1'b1, press_t);
      send_sample(1'b0, press_t + 1);
      press_t = press_t + $urandom_range(2, 40);
      send_sample(1'b1, press_t);
      send_sample(1'b1, press_t + sb.hold + $urandom_range(1, 100));
      send_sample(1'b0, press_t + sb.hold + $urandom_range(101, 200));
      now_ms = press_t + sb.hold + sb.tap_gap + $urandom_range(201, 400);
      send_sample(1'b0, now_ms);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        now_ms = now_ms + (($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 600));
        send_sample(1'($urandom_range(0, 1)), now_ms);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] gap_set[6];
    logic [CFG_W-1:0] hold_set[6];
    int               target;

    smp_bus.valid       <= 1'b0;
    smp_bus.touch_level <= 1'b0;
    smp_bus.time_ms     <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;

    gap_set  = '{TAP_GAP_RESET, 16'd0, 16'hFFFF, CFG_W'($urandom_range(0, 16'hFFFF)),
                 16'd20, 16'hFFFF};
    hold_set = '{HOLD_RESET, 16'd0, 16'hFFFF, CFG_W'($urandom_range(0, 16'hFFFF)),
                 16'd60, 16'd0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, strict gap and hold compares, wrap
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd10);
    send_sample(1'b1, 32'd400);         // exactly the gap: new sequence
    send_sample(1'b0, 32'd410);
    send_sample(1'b1, 32'd799);         // inside the gap: second tap
    send_sample(1'b0, 32'd800);
    send_sample(1'b0, 32'd1199);        // exactly the gap: no timeout yet
    send_sample(1'b0, 32'd1200);        // past the gap: two taps reported
    send_sample(1'b1, 32'd2000);
    send_sample(1'b1, 32'd3500);        // exactly hold: no event
    send_sample(1'b1, 32'd3501);        // past hold: hold event
    send_sample(1'b0, 32'd3600);        // release ends holding
    send_sample(1'b1, 32'hFFFF_FF00);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b1, 32'h0000_0010);   // tap across the timestamp wrap
    send_sample(1'b0, 32'h0000_0020);
    send_sample(1'b0, 32'h0000_0300);
    send_sample(1'b1, 32'h0000_1000);
    send_sample(1'b0, 32'h0000_1001);
    send_sample(1'b0, 32'h0000_1200);   // single tap reported

    // Rewrite defaults plus an unmapped index, then long press in a multi-tap
    program_regs(TAP_GAP_RESET, HOLD_RESET, 1'b1);
    send_sample(1'b1, 32'h0000_2000);
    send_sample(1'b0, 32'h0000_2001);
    send_sample(1'b1, 32'h0000_2002);
    send_sample(1'b1, 32'h0000_2002 + 32'd2000);
    send_sample(1'b0, 32'h0000_2002 + 32'd2001);

    // Saturating burst of taps well inside the gap
    now_ms = 32'h0001_0000;
    for (int k = 0; k < BURST_TAPS; k++) begin
      send_sample(1'b1, now_ms);
      send_sample(1'b0, now_ms + 1);
      now_ms = now_ms + 3;
    end
    now_ms = now_ms + 1000;
    send_sample(1'b0, now_ms);

    // Random gestures across register settings and stall profiles
    target = 750;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg != 0) program_regs(gap_set[seg], hold_set[seg], seg == 3);
      case (seg / 2)
        0: begin src_idle_pct = 27; sink_idle_pct = 50; end
        1: begin src_idle_pct = 50; sink_idle_pct = 27; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      // long sink hold-off while samples keep coming
      if (seg == 1) hold_off_seq <= hold_off_seq + 1'b1;
      while (items_sent < target) play_gesture();
      target = target + 110;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
